FILE: rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Types, codes and reset values shared by the wall-following controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wfc_pkg;

    localparam int SENSOR_BITS = 8;
    localparam int SPEED_BITS  = 10;
    localparam int CFG_BITS    = 10;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SENSOR_BITS-1:0] DEF_NEAR      = SENSOR_BITS'(50);
    localparam logic [SENSOR_BITS-1:0] DEF_FAR       = SENSOR_BITS'(40);
    localparam logic [SENSOR_BITS-1:0] DEF_TOO_CLOSE = SENSOR_BITS'(80);
    localparam logic [SPEED_BITS-1:0]  DEF_SPEED     = SPEED_BITS'(600);

    typedef logic [SENSOR_BITS-1:0] t_sensor;
    typedef logic [SPEED_BITS-1:0]  t_speed;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NEAR      = 2'd0,
        CFG_FAR       = 2'd1,
        CFG_TOO_CLOSE = 2'd2,
        CFG_SPEED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_STOP = 3'd0,
        CMD_FWD  = 3'd1,
        CMD_TL   = 3'd2,
        CMD_TR   = 3'd3,
        CMD_PL   = 3'd4,
        CMD_PR   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_SEARCH   = 3'd0,
        MODE_FOLLOW_R = 3'd1,
        MODE_FOLLOW_L = 3'd2,
        MODE_TURN_R   = 3'd3,
        MODE_TURN_L   = 3'd4,
        MODE_BACK     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        PH_DECIDE   = 3'd0,
        PH_PIVOT_L  = 3'd1,
        PH_PIVOT_R  = 3'd2,
        PH_APPROACH = 3'd3,
        PH_CHOOSE   = 3'd4,
        PH_WAIT_TR  = 3'd5,
        PH_WAIT_TL  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_LEFT  = 2'd2
    } t_side;

    typedef struct packed {
        t_sensor near_th;
        t_sensor far_th;
        t_sensor too_close_th;
        t_speed  speed;
    } t_cfg;

    typedef struct packed {
        t_cmd   cmd;
        t_speed speed;
        t_mode  mode;
        t_side  side;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/wall_following_robot_controller.sv
// ----------------------------------------------------------------------------
// wall_following_robot_controller
// Sensor-sample to motor-command controller for a wall-following robot.
// ----------------------------------------------------------------------------
// Each accepted left/front/right sample yields exactly one result: motor
// command, speed, the mode now in force and the followed side. A sample
// passes an input register, combinational decision logic and a result
// register, in that order. With no stall, one sample can be taken every
// cycle. The mode state advances when a sample moves from the input
// register into the result register. Write the configuration registers
// only while no sample is in flight.
`default_nettype none

module wall_following_robot_controller
    import wfc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [SENSOR_BITS-1:0]  i_left_distance,
    input  wire logic [SENSOR_BITS-1:0]  i_front_distance,
    input  wire logic [SENSOR_BITS-1:0]  i_right_distance,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [2:0]                   o_motor_command,
    output logic [SPEED_BITS-1:0]        o_motor_speed,
    output logic [2:0]                   o_current_mode,
    output logic [1:0]                   o_followed_side
);

    t_cfg    cfg;
    t_result core_res;

    logic    r_in_valid;
    t_sensor r_left;
    t_sensor r_front;
    t_sensor r_right;
    logic    r_out_valid;
    t_result r_out;

    logic out_ready;
    logic advance;
    logic in_accept;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    wfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wfc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_left   (r_left),
        .i_front  (r_front),
        .i_right  (r_right),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_left  <= i_left_distance;
            r_front <= i_front_distance;
            r_right <= i_right_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_command = r_out.cmd;
    assign o_motor_speed   = r_out.speed;
    assign o_current_mode  = r_out.mode;
    assign o_followed_side = r_out.side;

endmodule

`default_nettype wire

FILE: rtl/wfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfc_cfg_regs
// Threshold and speed registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_cfg_regs
    import wfc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    output t_cfg                         o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_th      <= DEF_NEAR;
            r_cfg.far_th       <= DEF_FAR;
            r_cfg.too_close_th <= DEF_TOO_CLOSE;
            r_cfg.speed        <= DEF_SPEED;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NEAR:      r_cfg.near_th      <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_FAR:       r_cfg.far_th       <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_TOO_CLOSE: r_cfg.too_close_th <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_SPEED:     r_cfg.speed        <= i_cfg_data[SPEED_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/wfc_core.sv
// ----------------------------------------------------------------------------
// wfc_core
// Mode, search phase, followed side and front-wall flag, with the decision
// logic that turns one sensor sample into the next state and a command.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_core
    import wfc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_update,
    input  t_sensor   i_left,
    input  t_sensor   i_front,
    input  t_sensor   i_right,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    t_mode  r_mode;
    t_phase r_phase;
    t_side  r_side;
    logic   r_fws;

    t_mode  n_mode;
    t_phase n_phase;
    t_side  n_side;
    logic   n_fws;
    t_cmd   n_cmd;

    always_comb begin
        t_mode  mode_in;
        t_phase phase_in;
        logic   l_near;
        logic   f_near;
        logic   r_near;
        logic   f_far;

        l_near = i_left  > i_cfg.near_th;
        f_near = i_front > i_cfg.near_th;
        r_near = i_right > i_cfg.near_th;
        f_far  = i_front < i_cfg.far_th;

        // fold unused codes back to search / decide
        unique case (r_mode)
            MODE_SEARCH, MODE_FOLLOW_R, MODE_FOLLOW_L,
            MODE_TURN_R, MODE_TURN_L, MODE_BACK: mode_in = r_mode;
            default:                             mode_in = MODE_SEARCH;
        endcase
        unique case (r_phase)
            PH_DECIDE, PH_PIVOT_L, PH_PIVOT_R, PH_APPROACH,
            PH_CHOOSE, PH_WAIT_TR, PH_WAIT_TL: phase_in = r_phase;
            default:                           phase_in = PH_DECIDE;
        endcase

        n_phase = phase_in;
        n_side  = r_side;
        n_fws   = r_fws;
        n_mode  = mode_in;

        // mode transition
        unique case (mode_in)
            MODE_FOLLOW_R: begin
                if (f_near)                          n_mode = MODE_TURN_L;
                else if (i_right < i_cfg.far_th)     n_mode = MODE_TURN_R;
                else if (r_near && l_near)           n_mode = MODE_BACK;
            end
            MODE_FOLLOW_L: begin
                if (f_near)                          n_mode = MODE_TURN_R;
                else if (i_left < i_cfg.far_th)      n_mode = MODE_TURN_L;
                else if (r_near && l_near)           n_mode = MODE_BACK;
            end
            MODE_TURN_R: begin
                if (l_near && f_far) begin
                    n_side = SIDE_LEFT;
                    n_mode = MODE_FOLLOW_L;
                end else if (r_near && f_far) begin
                    n_side = SIDE_RIGHT;
                    n_mode = MODE_FOLLOW_R;
                end
            end
            MODE_TURN_L: begin
                if (r_near && f_far) begin
                    n_side = SIDE_RIGHT;
                    n_mode = MODE_FOLLOW_R;
                end else if (l_near && f_far) begin
                    n_side = SIDE_LEFT;
                    n_mode = MODE_FOLLOW_L;
                end
            end
            MODE_BACK: begin
                if (f_near) n_fws = 1'b1;
                if (n_fws && f_far) begin
                    n_fws  = 1'b0;
                    n_mode = (r_side == SIDE_RIGHT) ? MODE_FOLLOW_R : MODE_FOLLOW_L;
                end
            end
            default: begin
                // leave search only between complete searches
                if (phase_in == PH_DECIDE) begin
                    if (f_near) begin
                        n_mode = r_near ? MODE_TURN_L : MODE_TURN_R;
                    end else if (r_near) begin
                        n_side = SIDE_RIGHT;
                        n_mode = MODE_FOLLOW_R;
                    end else if (l_near) begin
                        n_side = SIDE_LEFT;
                        n_mode = MODE_FOLLOW_L;
                    end
                end
            end
        endcase

        // action for the new mode, from the same sample
        unique case (n_mode)
            MODE_FOLLOW_R: begin
                n_side = SIDE_RIGHT;
                if (i_right < i_cfg.near_th)           n_cmd = CMD_TR;
                else if (i_right > i_cfg.too_close_th) n_cmd = CMD_TL;
                else                                   n_cmd = CMD_FWD;
            end
            MODE_FOLLOW_L: begin
                n_side = SIDE_LEFT;
                if (i_left < i_cfg.near_th)            n_cmd = CMD_TL;
                else if (i_left > i_cfg.too_close_th)  n_cmd = CMD_TR;
                else                                   n_cmd = CMD_FWD;
            end
            MODE_TURN_R: n_cmd = f_far ? CMD_TR : CMD_PR;
            MODE_TURN_L: n_cmd = f_far ? CMD_TL : CMD_PL;
            MODE_BACK:   n_cmd = (n_side == SIDE_RIGHT) ? CMD_PL : CMD_PR;
            default: begin
                unique case (phase_in)
                    PH_PIVOT_L: begin
                        if (i_left > i_front) begin
                            n_cmd = CMD_PL;
                        end else begin
                            n_phase = PH_APPROACH;
                            n_cmd   = CMD_FWD;
                        end
                    end
                    PH_PIVOT_R: begin
                        if (i_right > i_front) begin
                            n_cmd = CMD_PR;
                        end else begin
                            n_phase = PH_APPROACH;
                            n_cmd   = CMD_FWD;
                        end
                    end
                    PH_APPROACH: begin
                        if (i_front >= i_cfg.near_th) n_phase = PH_CHOOSE;
                        n_cmd = CMD_FWD;
                    end
                    PH_CHOOSE: begin
                        if (i_right < i_left) begin
                            n_phase = PH_WAIT_TR;
                            n_cmd   = CMD_TR;
                        end else begin
                            n_phase = PH_WAIT_TL;
                            n_cmd   = CMD_TL;
                        end
                    end
                    PH_WAIT_TR: begin
                        if (i_left < i_cfg.near_th) begin
                            n_cmd = CMD_TR;
                        end else begin
                            n_phase = PH_DECIDE;
                            n_cmd   = CMD_FWD;
                        end
                    end
                    PH_WAIT_TL: begin
                        if (i_right < i_cfg.near_th) begin
                            n_cmd = CMD_TL;
                        end else begin
                            n_phase = PH_DECIDE;
                            n_cmd   = CMD_FWD;
                        end
                    end
                    default: begin
                        if (i_front < i_left) begin
                            if (i_right < i_left) begin
                                n_phase = PH_PIVOT_L;
                                n_cmd   = CMD_PL;
                            end else begin
                                n_phase = PH_PIVOT_R;
                                n_cmd   = CMD_PR;
                            end
                        end else begin
                            n_phase = PH_APPROACH;
                            n_cmd   = CMD_FWD;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SEARCH;
            r_phase <= PH_DECIDE;
            r_side  <= SIDE_NONE;
            r_fws   <= 1'b0;
        end else if (i_update) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_side  <= n_side;
            r_fws   <= n_fws;
        end
    end

    assign o_result.cmd   = n_cmd;
    assign o_result.speed = (n_cmd == CMD_STOP) ? '0 : i_cfg.speed;
    assign o_result.mode  = n_mode;
    assign o_result.side  = n_side;

endmodule

`default_nettype wire

FILE: tb/tb_wall_following_robot_controller.sv
// ----------------------------------------------------------------------------
// tb_wall_following_robot_controller
// Self-checking bench for the wall-following robot controller.
// ----------------------------------------------------------------------------
// Left/front/right sensor samples go in through the valid/stall input
// channel. A behavioral model of the controller, kept inside this bench,
// holds its own mode, search phase, followed side and threshold settings.
// For every accepted sample it queues the expected command, speed, mode and
// side. Every result transaction is then checked against the oldest queued
// entry. The run covers a directed walk through the wall search and the
// follow/turn/turn-back modes, and random samples clustered around the
// thresholds under several register settings, the extremes among them. It
// also has random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_wall_following_robot_controller;
    import wfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 40;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_NEAR;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    t_sensor                 i_left_distance = '0;
    t_sensor                 i_front_distance = '0;
    t_sensor                 i_right_distance = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [2:0]              o_motor_command;
    logic [SPEED_BITS-1:0]   o_motor_speed;
    logic [2:0]              o_current_mode;
    logic [1:0]              o_followed_side;

    wall_following_robot_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_distance  (i_left_distance),
        .i_front_distance (i_front_distance),
        .i_right_distance (i_right_distance),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_motor_command  (o_motor_command),
        .o_motor_speed    (o_motor_speed),
        .o_current_mode   (o_current_mode),
        .o_followed_side  (o_followed_side)
    );

    // Robot model state and settings
    t_mode   bot_mode;
    t_phase  bot_phase;
    t_side   bot_side;
    bit      bot_front_seen;
    t_sensor th_near;
    t_sensor th_far;
    t_sensor th_close;
    t_speed  cruise_speed;

    t_result     pending_moves[$];
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned settings_loaded = 0;
    int unsigned in_stall_hits = 0;
    int unsigned cycle_count = 0;
    int          hold_request = 0;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Behavioral model
    // ------------------------------------------------------------------
    function automatic t_mode next_bot_mode(t_sensor l, t_sensor f, t_sensor r);
        case (bot_mode)
            MODE_FOLLOW_R: begin
                if (f > th_near) return MODE_TURN_L;
                if (r < th_far) return MODE_TURN_R;
                if (r > th_near && l > th_near) return MODE_BACK;
                return MODE_FOLLOW_R;
            end
            MODE_FOLLOW_L: begin
                if (f > th_near) return MODE_TURN_R;
                if (l < th_far) return MODE_TURN_L;
                if (r > th_near && l > th_near) return MODE_BACK;
                return MODE_FOLLOW_L;
            end
            MODE_TURN_R: begin
                if (l > th_near && f < th_far) begin
                    bot_side = SIDE_LEFT;
                    return MODE_FOLLOW_L;
                end
                if (r > th_near && f < th_far) begin
                    bot_side = SIDE_RIGHT;
                    return MODE_FOLLOW_R;
                end
                return MODE_TURN_R;
            end
            MODE_TURN_L: begin
                if (r > th_near && f < th_far) begin
                    bot_side = SIDE_RIGHT;
                    return MODE_FOLLOW_R;
                end
                if (l > th_near && f < th_far) begin
                    bot_side = SIDE_LEFT;
                    return MODE_FOLLOW_L;
                end
                return MODE_TURN_L;
            end
            MODE_BACK: begin
                if (f > th_near) bot_front_seen = 1'b1;
                // go back to following once the front wall has come and gone
                if (bot_front_seen && f < th_far) begin
                    bot_front_seen = 1'b0;
                    return (bot_side == SIDE_RIGHT) ? MODE_FOLLOW_R : MODE_FOLLOW_L;
                end
                return MODE_BACK;
            end
            default: begin
                // leave the search only between complete searches
                if (bot_phase != PH_DECIDE) return MODE_SEARCH;
                if (f > th_near) return (r > th_near) ? MODE_TURN_L : MODE_TURN_R;
                if (r > th_near) begin
                    bot_side = SIDE_RIGHT;
                    return MODE_FOLLOW_R;
                end
                if (l > th_near) begin
                    bot_side = SIDE_LEFT;
                    return MODE_FOLLOW_L;
                end
                return MODE_SEARCH;
            end
        endcase
    endfunction

    function automatic t_cmd search_command(t_sensor l, t_sensor f, t_sensor r);
        case (bot_phase)
            PH_PIVOT_L: begin
                if (l > f) return CMD_PL;
                bot_phase = PH_APPROACH;
                return CMD_FWD;
            end
            PH_PIVOT_R: begin
                if (r > f) return CMD_PR;
                bot_phase = PH_APPROACH;
                return CMD_FWD;
            end
            PH_APPROACH: begin
                if (f >= th_near) bot_phase = PH_CHOOSE;
                return CMD_FWD;
            end
            PH_CHOOSE: begin
                if (r < l) begin
                    bot_phase = PH_WAIT_TR;
                    return CMD_TR;
                end
                bot_phase = PH_WAIT_TL;
                return CMD_TL;
            end
            PH_WAIT_TR: begin
                if (l < th_near) return CMD_TR;
                bot_phase = PH_DECIDE;
                return CMD_FWD;
            end
            PH_WAIT_TL: begin
                if (r < th_near) return CMD_TL;
                bot_phase = PH_DECIDE;
                return CMD_FWD;
            end
            default: begin
                if (f < l) begin
                    if (r < l) begin
                        bot_phase = PH_PIVOT_L;
                        return CMD_PL;
                    end
                    bot_phase = PH_PIVOT_R;
                    return CMD_PR;
                end
                bot_phase = PH_APPROACH;
                return CMD_FWD;
            end
        endcase
    endfunction

    function automatic t_cmd steer_command(t_sensor l, t_sensor f, t_sensor r);
        case (bot_mode)
            MODE_FOLLOW_R: begin
                bot_side = SIDE_RIGHT;
                if (r < th_near) return CMD_TR;
                if (r > th_close) return CMD_TL;
                return CMD_FWD;
            end
            MODE_FOLLOW_L: begin
                bot_side = SIDE_LEFT;
                if (l < th_near) return CMD_TL;
                if (l > th_close) return CMD_TR;
                return CMD_FWD;
            end
            MODE_TURN_R: return (f < th_far) ? CMD_TR : CMD_PR;
            MODE_TURN_L: return (f < th_far) ? CMD_TL : CMD_PL;
            MODE_BACK:   return (bot_side == SIDE_RIGHT) ? CMD_PL : CMD_PR;
            default:     return search_command(l, f, r);
        endcase
    endfunction

    function automatic t_result predict_move(t_sensor l, t_sensor f, t_sensor r);
        t_result move;
        t_cmd    cmd;
        bot_mode   = next_bot_mode(l, f, r);
        cmd        = steer_command(l, f, r);
        move.cmd   = cmd;
        move.speed = (cmd == CMD_STOP) ? t_speed'(0) : cruise_speed;
        move.mode  = bot_mode;
        move.side  = bot_side;
        return move;
    endfunction

    // Readings clustered around the current thresholds, with some full range
    function automatic t_sensor pick_reading();
        int v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 255);
            1:       v = $urandom_range(0, th_far);
            2:       v = $urandom_range(th_near, 255);
            3:       v = int'(th_near) + int'($urandom_range(0, 4)) - 2;
            4:       v = int'(th_far) + int'($urandom_range(0, 4)) - 2;
            default: v = int'(th_close) + int'($urandom_range(0, 4)) - 2;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_sensor'(v);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_sample(input t_sensor l, input t_sensor f, input t_sensor r);
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_left_distance  <= l;
        i_front_distance <= f;
        i_right_distance <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_moves.push_back(predict_move(l, f, r));
        samples_sent++;
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic settle_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_moves.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_sensor nr, input t_sensor fa,
                                 input t_sensor tc, input t_speed spd);
        settle_block();
        put_reg(CFG_NEAR, CFG_BITS'(nr));
        put_reg(CFG_FAR, CFG_BITS'(fa));
        put_reg(CFG_TOO_CLOSE, CFG_BITS'(tc));
        put_reg(CFG_SPEED, CFG_BITS'(spd));
        i_cfg_we     <= 1'b0;
        th_near      = nr;
        th_far       = fa;
        th_close     = tc;
        cruise_speed = spd;
        settings_loaded++;
    endtask

    // Receiver stall: random bursts, or a long hold when one is requested
    initial begin : out_stall_gen
        int burst_left;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                burst_left   = hold_request;
                hold_request = 0;
            end
            if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 7) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [SPEED_BITS-1:0] got,
                                   input logic [SPEED_BITS-1:0] want);
        if (mismatch_count < 40)
            $display("[%0t] MISMATCH result %0d %s: got %0d, expected %0d",
                     $realtime, results_checked, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_in_valid && o_in_stall) in_stall_hits++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_moves.size() == 0) begin
                report_mismatch("unexpected transaction, command",
                                SPEED_BITS'(o_motor_command), '0);
            end else begin
                due = pending_moves.pop_front();
                if (o_motor_command !== due.cmd)
                    report_mismatch("motor_command", SPEED_BITS'(o_motor_command),
                                    SPEED_BITS'(due.cmd));
                if (o_motor_speed !== due.speed)
                    report_mismatch("motor_speed", o_motor_speed, due.speed);
                if (o_current_mode !== due.mode)
                    report_mismatch("current_mode", SPEED_BITS'(o_current_mode),
                                    SPEED_BITS'(due.mode));
                if (o_followed_side !== due.side)
                    report_mismatch("followed_side", SPEED_BITS'(o_followed_side),
                                    SPEED_BITS'(due.side));
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding",
                     $realtime, pending_moves.size());
            $display("** wall_following_robot_controller: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        bot_mode       = MODE_SEARCH;
        bot_phase      = PH_DECIDE;
        bot_side       = SIDE_NONE;
        bot_front_seen = 1'b0;
        th_near        = DEF_NEAR;
        th_far         = DEF_FAR;
        th_close       = DEF_TOO_CLOSE;
        cruise_speed   = DEF_SPEED;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Walk every search phase under reset thresholds, then leave the search
    // and pass through following, turning and turn-back.
    task automatic test_search_and_modes();
        t_sensor walk[25][3] = '{
            '{8'd0,   8'd0,   8'd0},    // decide, drive forward
            '{8'd50,  8'd50,  8'd50},   // approach ends at near
            '{8'd40,  8'd255, 8'd30},   // choose: turn right
            '{8'd49,  8'd0,   8'd255},  // keep turning right
            '{8'd50,  8'd0,   8'd0},    // back to decide
            '{8'd30,  8'd10,  8'd20},   // decide: pivot left
            '{8'd30,  8'd10,  8'd20},
            '{8'd10,  8'd10,  8'd20},   // pivot done
            '{8'd0,   8'd255, 8'd0},
            '{8'd10,  8'd0,   8'd10},   // choose: turn left
            '{8'd0,   8'd0,   8'd49},
            '{8'd255, 8'd255, 8'd50},
            '{8'd30,  8'd10,  8'd40},   // decide: pivot right
            '{8'd0,   8'd10,  8'd40},
            '{8'd0,   8'd40,  8'd40},
            '{8'd0,   8'd49,  8'd0},
            '{8'd0,   8'd50,  8'd0},
            '{8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd255},
            '{8'd51,  8'd60,  8'd255},  // front and right near: turn left
            '{8'd10,  8'd10,  8'd255},  // right wall found, too close
            '{8'd60,  8'd10,  8'd60},   // both sides near: turn back
            '{8'd0,   8'd255, 8'd0},    // front wall seen
            '{8'd0,   8'd0,   8'd0},    // front clear: follow again
            '{8'd255, 8'd255, 8'd255}
        };
        foreach (walk[i]) send_sample(walk[i][0], walk[i][1], walk[i][2]);
    endtask

    task automatic test_random_samples(input int count);
        repeat (count) send_sample(pick_reading(), pick_reading(), pick_reading());
    endtask

    // Hold the result side long enough for the block to fill and stall input
    task automatic test_receiver_hold();
        hold_request = HOLD_CYCLES;
        test_random_samples(16);
    endtask

    task automatic test_random_settings(input int count);
        t_sensor nr;
        nr = t_sensor'($urandom_range(30, 150));
        load_settings(nr, t_sensor'($urandom_range(5, nr)),
                      t_sensor'($urandom_range(nr, 250)),
                      t_speed'($urandom_range(0, 1023)));
        test_random_samples(count);
    endtask

    initial begin
        apply_reset();
        test_search_and_modes();
        test_random_samples(300);
        test_receiver_hold();

        load_settings(8'd255, 8'd255, 8'd255, 10'd1023);
        test_random_samples(80);
        load_settings(8'd0, 8'd0, 8'd0, 10'd0);
        test_random_samples(80);

        test_random_settings(250);
        test_random_settings(150);

        // closing stretch: back to reset thresholds, no idling
        load_settings(DEF_NEAR, DEF_FAR, DEF_TOO_CLOSE, DEF_SPEED);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_random_samples(200);

        settle_block();
        if (pending_moves.size() != 0) report_mismatch("results never seen", '0, '0);

        $display("Covered: %0d samples sent, %0d results checked, %0d register loads,",
                 samples_sent, results_checked, settings_loaded);
        $display("         input stalled on %0d cycles, %0d mismatches",
                 in_stall_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("** wall_following_robot_controller: PASSED **");
        else
            $display("** wall_following_robot_controller: FAILED **");
        $finish;
    end

endmodule
